FILE: rtl/core/lfps_pkg.sv
`timescale 1ns / 1ps
// lfps_pkg: shared types and constants of the line-follow pid steering block
// used by lfps_term_lane, lfps_merge and line_follow_pid_steering; no dependencies

package lfps_pkg;

	localparam int SENSOR_BITS    = 12;
	localparam int SPEED_BITS     = 10;
	localparam int GAIN_FRAC_BITS = 8;
	localparam int GAIN_BITS      = 12;
	localparam int POS_BITS       = 12;
	localparam int THRESH_BITS    = 12;
	localparam int ERR_BITS       = 14;
	localparam int DERIV_BITS     = ERR_BITS + 1;
	localparam int SUM_BITS       = 32;
	localparam int P_PROD_BITS    = ERR_BITS + GAIN_BITS + 1;
	localparam int I_PROD_BITS    = SUM_BITS + GAIN_BITS + 1;
	localparam int D_PROD_BITS    = DERIV_BITS + GAIN_BITS + 1;
	localparam int ACC_BITS       = 48;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 12;

	localparam logic [GAIN_BITS-1:0]   GAIN_P_RST      = 12'd51;
	localparam logic [GAIN_BITS-1:0]   GAIN_I_RST      = 12'd0;
	localparam logic [GAIN_BITS-1:0]   GAIN_D_RST      = 12'd102;
	localparam logic [SPEED_BITS-1:0]  BASE_SPEED_RST  = 10'd350;
	localparam logic [SPEED_BITS-1:0]  SPEED_LIMIT_RST = 10'd500;
	localparam logic [THRESH_BITS-1:0] THRESHOLD_RST   = 12'd700;
	localparam logic [POS_BITS-1:0]    SETPOINT_RST    = 12'd2500;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GAIN_P          = 3'd0,
		REG_GAIN_I          = 3'd1,
		REG_GAIN_D          = 3'd2,
		REG_BASE_SPEED      = 3'd3,
		REG_SPEED_LIMIT     = 3'd4,
		REG_BLACK_THRESHOLD = 3'd5,
		REG_SETPOINT        = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [SENSOR_BITS-1:0] sensor_0;
		logic [SENSOR_BITS-1:0] sensor_1;
		logic [SENSOR_BITS-1:0] sensor_2;
		logic [SENSOR_BITS-1:0] sensor_3;
		logic [SENSOR_BITS-1:0] sensor_4;
		logic [POS_BITS-1:0]    line_position;
	} sample_t;

	typedef struct packed {
		logic [SPEED_BITS-1:0] left_speed;
		logic [SPEED_BITS-1:0] right_speed;
		logic                  line_seen;
	} drive_t;

	typedef struct packed {
		logic valid;
		logic seen;
	} lane_ctl_t;

endpackage

FILE: rtl/core/lfps_term_lane.sv
`timescale 1ns / 1ps
// lfps_term_lane: one pid term lane, unsigned q4.8 gain times signed operand, registered
// depends on lfps_pkg

module lfps_term_lane #(
	parameter int OP_BITS = 14
) (
	input  logic                                     clk,
	input  logic [lfps_pkg::GAIN_BITS-1:0]           gain,
	input  logic signed [OP_BITS-1:0]                operand,
	output logic signed [OP_BITS+lfps_pkg::GAIN_BITS:0] prod_s2
);

	logic signed [lfps_pkg::GAIN_BITS:0] gain_sx;

	assign gain_sx = $signed({1'b0, gain});

	always_ff @(posedge clk) begin
		prod_s2 <= gain_sx * operand;
	end

endmodule

FILE: rtl/core/lfps_merge.sv
`timescale 1ns / 1ps
// lfps_merge: sums the three term lanes, then forms and clamps both motor speeds
// when a line is seen, else sends base speed to both; depends on lfps_pkg

module lfps_merge (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  lfps_pkg::lane_ctl_t                         ctl_s2,
	input  logic signed [lfps_pkg::P_PROD_BITS-1:0]     p_s2,
	input  logic signed [lfps_pkg::I_PROD_BITS-1:0]     i_s2,
	input  logic signed [lfps_pkg::D_PROD_BITS-1:0]     d_s2,
	input  logic [lfps_pkg::SPEED_BITS-1:0]             base_speed,
	input  logic [lfps_pkg::SPEED_BITS-1:0]             speed_limit,
	output logic                                        valid_s4,
	output lfps_pkg::drive_t                            result_s4
);

	localparam int WHOLE_BITS = lfps_pkg::ACC_BITS - lfps_pkg::GAIN_FRAC_BITS;

	function automatic logic [lfps_pkg::SPEED_BITS-1:0] clamp_speed(
		input logic signed [lfps_pkg::ACC_BITS-1:0] num,
		input logic [lfps_pkg::SPEED_BITS-1:0]      limit
	);
		logic [WHOLE_BITS-1:0] whole;
		logic [lfps_pkg::SPEED_BITS-1:0] res;
		whole = num[lfps_pkg::ACC_BITS-1:lfps_pkg::GAIN_FRAC_BITS];
		if (num[lfps_pkg::ACC_BITS-1]) begin
			res = '0;
		end else if (whole > WHOLE_BITS'(limit)) begin
			res = limit;
		end else begin
			res = whole[lfps_pkg::SPEED_BITS-1:0];
		end
		return res;
	endfunction

	lfps_pkg::lane_ctl_t                 ctl_s3;
	logic signed [lfps_pkg::ACC_BITS-1:0] acc_s3;
	logic signed [lfps_pkg::ACC_BITS-1:0] base_num;
	logic signed [lfps_pkg::ACC_BITS-1:0] num_left;
	logic signed [lfps_pkg::ACC_BITS-1:0] num_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		acc_s3 <= lfps_pkg::ACC_BITS'(p_s2) + lfps_pkg::ACC_BITS'(i_s2)
			+ lfps_pkg::ACC_BITS'(d_s2);
	end

	assign base_num  = $signed(lfps_pkg::ACC_BITS'({base_speed,
		{lfps_pkg::GAIN_FRAC_BITS{1'b0}}}));
	assign num_left  = base_num + acc_s3;
	assign num_right = base_num - acc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s3.seen) begin
			result_s4.left_speed  <= clamp_speed(num_left, speed_limit);
			result_s4.right_speed <= clamp_speed(num_right, speed_limit);
			result_s4.line_seen   <= 1'b1;
		end else begin
			result_s4.left_speed  <= base_speed;
			result_s4.right_speed <= base_speed;
			result_s4.line_seen   <= 1'b0;
		end
	end

endmodule

FILE: rtl/core/line_follow_pid_steering.sv
`timescale 1ns / 1ps
// line_follow_pid_steering: top level, config registers, error and integral stage,
// three pid term lanes, merge stage and output queue; depends on lfps_pkg,
// lfps_term_lane and lfps_merge
//
// usage
//   sample channel (sample_valid/sample_ready/sample): five reflectance readings
//   and a line position per beat. drive channel (drive_valid/drive_ready/drive):
//   left and right motor speed plus a line_seen flag, one beat per sample beat,
//   in order. cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
//   gain, speed, threshold and setpoint registers; cfg_ready is always high. The user
//   must make writes only while the block is idle; the block does not enforce it.
//   path: a sample passes the stage 1 registers, the term lanes, the merge
//   stages and the output queue register before it shows up on drive.
//   throughput: one sample per cycle while sample_ready is high; the integral
//   and previous error update at sample acceptance, the three gain multiplies
//   run as parallel lanes, and the merge stage sums and clamps in two more stages.
//   stall: results queue in a FIFO_DEPTH entry output queue; sample_ready drops
//   once FIFO_DEPTH samples are in flight or waiting, so no beat is lost.
//   reset: arst_n clears the pipeline valid flags, the queue pointers and counts,
//   the integral and the previous error, and loads the register defaults.

module line_follow_pid_steering #(
	parameter int FIFO_DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   sample_valid,
	output logic                                   sample_ready,
	input  lfps_pkg::sample_t                      sample,
	output logic                                   drive_valid,
	input  logic                                   drive_ready,
	output lfps_pkg::drive_t                       drive,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lfps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [lfps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

	// config registers
	logic [lfps_pkg::GAIN_BITS-1:0]   gain_p_q;
	logic [lfps_pkg::GAIN_BITS-1:0]   gain_i_q;
	logic [lfps_pkg::GAIN_BITS-1:0]   gain_d_q;
	logic [lfps_pkg::SPEED_BITS-1:0]  base_speed_q;
	logic [lfps_pkg::SPEED_BITS-1:0]  speed_limit_q;
	logic [lfps_pkg::THRESH_BITS-1:0] threshold_q;
	logic [lfps_pkg::POS_BITS-1:0]    setpoint_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= lfps_pkg::GAIN_P_RST;
			gain_i_q      <= lfps_pkg::GAIN_I_RST;
			gain_d_q      <= lfps_pkg::GAIN_D_RST;
			base_speed_q  <= lfps_pkg::BASE_SPEED_RST;
			speed_limit_q <= lfps_pkg::SPEED_LIMIT_RST;
			threshold_q   <= lfps_pkg::THRESHOLD_RST;
			setpoint_q    <= lfps_pkg::SETPOINT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lfps_pkg::REG_GAIN_P: begin
					gain_p_q <= cfg_data[lfps_pkg::GAIN_BITS-1:0];
				end
				lfps_pkg::REG_GAIN_I: begin
					gain_i_q <= cfg_data[lfps_pkg::GAIN_BITS-1:0];
				end
				lfps_pkg::REG_GAIN_D: begin
					gain_d_q <= cfg_data[lfps_pkg::GAIN_BITS-1:0];
				end
				lfps_pkg::REG_BASE_SPEED: begin
					base_speed_q <= cfg_data[lfps_pkg::SPEED_BITS-1:0];
				end
				lfps_pkg::REG_SPEED_LIMIT: begin
					speed_limit_q <= cfg_data[lfps_pkg::SPEED_BITS-1:0];
				end
				lfps_pkg::REG_BLACK_THRESHOLD: begin
					threshold_q <= cfg_data[lfps_pkg::THRESH_BITS-1:0];
				end
				lfps_pkg::REG_SETPOINT: begin
					setpoint_q <= cfg_data[lfps_pkg::POS_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// stage 1: line detect, error, saturating integral, derivative
	logic                                  accept;
	logic                                  seen_c;
	logic signed [lfps_pkg::ERR_BITS-1:0]   err_c;
	logic signed [lfps_pkg::SUM_BITS:0]     sum_wide;
	logic signed [lfps_pkg::SUM_BITS-1:0]   sum_c;
	logic signed [lfps_pkg::DERIV_BITS-1:0] deriv_c;
	logic signed [lfps_pkg::SUM_BITS-1:0]   error_sum_q;
	logic signed [lfps_pkg::ERR_BITS-1:0]   prev_err_q;

	assign accept = sample_valid && sample_ready;

	assign seen_c = (lfps_pkg::THRESH_BITS'(sample.sensor_0) < threshold_q)
		|| (lfps_pkg::THRESH_BITS'(sample.sensor_1) < threshold_q)
		|| (lfps_pkg::THRESH_BITS'(sample.sensor_2) < threshold_q)
		|| (lfps_pkg::THRESH_BITS'(sample.sensor_3) < threshold_q)
		|| (lfps_pkg::THRESH_BITS'(sample.sensor_4) < threshold_q);

	assign err_c = $signed(lfps_pkg::ERR_BITS'(sample.line_position))
		- $signed(lfps_pkg::ERR_BITS'(setpoint_q));

	assign sum_wide = (lfps_pkg::SUM_BITS+1)'(error_sum_q)
		+ (lfps_pkg::SUM_BITS+1)'(err_c);

	always_comb begin
		if (sum_wide[lfps_pkg::SUM_BITS] != sum_wide[lfps_pkg::SUM_BITS-1]) begin
			sum_c = sum_wide[lfps_pkg::SUM_BITS] ?
				{1'b1, {(lfps_pkg::SUM_BITS-1){1'b0}}} :
				{1'b0, {(lfps_pkg::SUM_BITS-1){1'b1}}};
		end else begin
			sum_c = sum_wide[lfps_pkg::SUM_BITS-1:0];
		end
	end

	assign deriv_c = lfps_pkg::DERIV_BITS'(err_c) - lfps_pkg::DERIV_BITS'(prev_err_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			prev_err_q  <= '0;
		end else if (accept) begin
			if (seen_c) begin
				error_sum_q <= sum_c;
				prev_err_q  <= err_c;
			end else begin
				error_sum_q <= '0;
				prev_err_q  <= '0;
			end
		end
	end

	lfps_pkg::lane_ctl_t                    ctl_s1;
	lfps_pkg::lane_ctl_t                    ctl_s2;
	logic signed [lfps_pkg::ERR_BITS-1:0]   err_s1;
	logic signed [lfps_pkg::SUM_BITS-1:0]   sum_s1;
	logic signed [lfps_pkg::DERIV_BITS-1:0] deriv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.seen  <= seen_c;
			ctl_s2       <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1   <= err_c;
			sum_s1   <= sum_c;
			deriv_s1 <= deriv_c;
		end
	end

	// stage 2: term lanes
	logic signed [lfps_pkg::P_PROD_BITS-1:0] p_s2;
	logic signed [lfps_pkg::I_PROD_BITS-1:0] i_s2;
	logic signed [lfps_pkg::D_PROD_BITS-1:0] d_s2;

	lfps_term_lane #(.OP_BITS(lfps_pkg::ERR_BITS)) u_lane_p (
		.clk     (clk),
		.gain    (gain_p_q),
		.operand (err_s1),
		.prod_s2 (p_s2)
	);

	lfps_term_lane #(.OP_BITS(lfps_pkg::SUM_BITS)) u_lane_i (
		.clk     (clk),
		.gain    (gain_i_q),
		.operand (sum_s1),
		.prod_s2 (i_s2)
	);

	lfps_term_lane #(.OP_BITS(lfps_pkg::DERIV_BITS)) u_lane_d (
		.clk     (clk),
		.gain    (gain_d_q),
		.operand (deriv_s1),
		.prod_s2 (d_s2)
	);

	// stages 3 and 4: merge
	logic             valid_s4;
	lfps_pkg::drive_t result_s4;

	lfps_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_s2      (ctl_s2),
		.p_s2        (p_s2),
		.i_s2        (i_s2),
		.d_s2        (d_s2),
		.base_speed  (base_speed_q),
		.speed_limit (speed_limit_q),
		.valid_s4    (valid_s4),
		.result_s4   (result_s4)
	);

	// output queue with credit count over everything in flight
	lfps_pkg::drive_t      fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [CNT_BITS-1:0]   fcnt_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  pop;

	assign sample_ready = cnt_q < CNT_BITS'(FIFO_DEPTH);
	assign drive_valid  = fcnt_q != '0;
	assign drive        = fifo_q[rd_ptr_q];
	assign pop          = drive_valid && drive_ready;

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			fifo_q[wr_ptr_q] <= result_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
			cnt_q    <= '0;
		end else begin
			if (valid_s4) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({valid_s4, pop})
				2'b10:   fcnt_q <= fcnt_q + 1'b1;
				2'b01:   fcnt_q <= fcnt_q - 1'b1;
				default: fcnt_q <= fcnt_q;
			endcase
			case ({accept, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// checks
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(FIFO_DEPTH))
		else $error("in-flight count above queue depth");

	a_queue_within_credit: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= cnt_q)
		else $error("queue holds more beats than accepted");

	a_clear_on_lost_line: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !seen_c) |=> (error_sum_q == '0 && prev_err_q == '0))
		else $error("pid memory not cleared when line lost");

	a_straight_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(drive_valid && !drive.line_seen) |-> (drive.left_speed == drive.right_speed))
		else $error("straight mode speeds differ");

	a_write_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (fcnt_q < CNT_BITS'(FIFO_DEPTH) || pop))
		else $error("result written into full queue");

endmodule

FILE: sim/line_follow_pid_steering_tb.sv
`timescale 1ns / 1ps
// line_follow_pid_steering_tb: self-checking bench for the line-follow pid steering block,
// directed table then randomized phases and a full-error run, checked by table or predictor
// depends on lfps_pkg and line_follow_pid_steering

module line_follow_pid_steering_tb;

	localparam int CLK_HALF        = 10;
	localparam int RESET_CYCLES    = 9;
	localparam int RAND_PHASES     = 9;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int FULL_ERR_ITEMS  = 40;
	localparam int SETTLE_CYCLES   = 8;
	localparam int DRAIN_CYCLES    = 20;
	localparam int CYCLE_LIMIT     = 3_000_000;
	localparam logic [lfps_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -64'sd2147483648;

	typedef struct {
		logic [11:0] gp, gi, gd, base, limit, thr, sp;
	} setting_t;

	typedef struct {
		lfps_pkg::sample_t s;
		bit                typed;
		lfps_pkg::drive_t  want;
	} stim_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                sample_valid;
	logic                                sample_ready;
	lfps_pkg::sample_t                   sample;
	logic                                drive_valid;
	logic                                drive_ready;
	lfps_pkg::drive_t                    drive;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [lfps_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [lfps_pkg::CFG_DATA_BITS-1:0]  cfg_data;

	// predictor copy of the registers and the pid memory
	logic [lfps_pkg::GAIN_BITS-1:0]   k_p, k_i, k_d;
	logic [lfps_pkg::SPEED_BITS-1:0]  base_spd, spd_limit;
	logic [lfps_pkg::THRESH_BITS-1:0] black_thr;
	logic [lfps_pkg::POS_BITS-1:0]    target_pos;
	int                               integ_sum;
	int                               last_err;

	lfps_pkg::drive_t pending_drive [$];
	stim_row_t        directed_rows [$];
	int               fail_count;
	int               cycle_count;
	int               send_idle_pct;
	int               stall_pct;
	int               line_run;

	line_follow_pid_steering dut (
		.clk,
		.arst_n,
		.sample_valid,
		.sample_ready,
		.sample,
		.drive_valid,
		.drive_ready,
		.drive,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	always #CLK_HALF clk = ~clk;

	function automatic logic [lfps_pkg::SPEED_BITS-1:0] speed_of(longint num);
		longint v;
		longint lim;
		lim = spd_limit;
		v = num / (longint'(1) << lfps_pkg::GAIN_FRAC_BITS);
		if (v < 0)
			v = 0;
		if (v > lim)
			v = lim;
		return v[lfps_pkg::SPEED_BITS-1:0];
	endfunction

	function automatic lfps_pkg::drive_t predict_drive(lfps_pkg::sample_t s);
		lfps_pkg::drive_t d;
		bit     seen;
		longint pos, sp, err, sum, deriv, acc, base_num, gp, gi, gd, b;
		seen = (s.sensor_0 < black_thr) || (s.sensor_1 < black_thr) ||
			(s.sensor_2 < black_thr) || (s.sensor_3 < black_thr) ||
			(s.sensor_4 < black_thr);
		d.line_seen = seen;
		if (!seen) begin
			integ_sum = 0;
			last_err = 0;
			d.left_speed = base_spd;
			d.right_speed = base_spd;
			return d;
		end
		pos = s.line_position;
		sp = target_pos;
		err = pos - sp;
		sum = integ_sum;
		sum = sum + err;
		if (sum > SUM_MAX)
			sum = SUM_MAX;
		if (sum < SUM_MIN)
			sum = SUM_MIN;
		integ_sum = int'(sum);
		deriv = err - longint'(last_err);
		last_err = int'(err);
		gp = k_p;
		gi = k_i;
		gd = k_d;
		b = base_spd;
		acc = gp * err + gi * sum + gd * deriv;
		base_num = b * (longint'(1) << lfps_pkg::GAIN_FRAC_BITS);
		d.left_speed = speed_of(base_num + acc);
		d.right_speed = speed_of(base_num - acc);
		return d;
	endfunction

	function automatic void field_check(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			fail_count++;
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endfunction

	function automatic lfps_pkg::sample_t random_sample();
		lfps_pkg::sample_t s;
		logic [11:0] rd [5];
		logic [11:0] thr;
		int          k, p;
		bit          noise;
		thr = black_thr;
		noise = ($urandom_range(99) < 12);
		if (line_run == 0 && $urandom_range(3) != 0)
			line_run = int'($urandom_range(40, 1));
		for (k = 0; k < 5; k++) begin
			if (noise)
				rd[k] = 12'($urandom_range(4095, 0));
			else if (line_run > 0 && thr != 0 && $urandom_range(3) == 0)
				rd[k] = 12'($urandom_range(thr - 1, 0));
			else
				rd[k] = 12'($urandom_range(4095, thr));
		end
		if (!noise && line_run > 0) begin
			line_run--;
			if (thr != 0)
				rd[$urandom_range(4, 0)] = 12'($urandom_range(thr - 1, 0));
		end
		s.sensor_0 = rd[0];
		s.sensor_1 = rd[1];
		s.sensor_2 = rd[2];
		s.sensor_3 = rd[3];
		s.sensor_4 = rd[4];
		k = int'($urandom_range(99));
		if (k < 60) begin
			p = int'(target_pos) + int'($urandom_range(80)) - 40;
			if (p < 0)
				p = 0;
			if (p > 4095)
				p = 4095;
			s.line_position = p[11:0];
		end else if (k < 90) begin
			s.line_position = 12'($urandom_range(4000, 0));
		end else begin
			s.line_position = 12'($urandom_range(4095, 0));
		end
		return s;
	endfunction

	task automatic add_row(input logic [11:0] s0, s1, s2, s3, s4, pos, input bit typed,
		input logic [9:0] l, r, input logic seen);
		stim_row_t row;
		row.s = '{sensor_0: s0, sensor_1: s1, sensor_2: s2, sensor_3: s3, sensor_4: s4,
			line_position: pos};
		row.typed = typed;
		row.want = '{left_speed: l, right_speed: r, line_seen: seen};
		directed_rows.push_back(row);
	endtask

	task automatic send_sample(input lfps_pkg::sample_t s, input bit typed,
		input lfps_pkg::drive_t want);
		int               gap;
		lfps_pkg::drive_t pred;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		pred = predict_drive(s);
		pending_drive.push_back(typed ? want : pred);
	endtask

	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [lfps_pkg::CFG_INDEX_BITS-1:0] idx,
		input logic [lfps_pkg::CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			lfps_pkg::REG_GAIN_P:          k_p = data;
			lfps_pkg::REG_GAIN_I:          k_i = data;
			lfps_pkg::REG_GAIN_D:          k_d = data;
			lfps_pkg::REG_BASE_SPEED:      base_spd = data[lfps_pkg::SPEED_BITS-1:0];
			lfps_pkg::REG_SPEED_LIMIT:     spd_limit = data[lfps_pkg::SPEED_BITS-1:0];
			lfps_pkg::REG_BLACK_THRESHOLD: black_thr = data;
			lfps_pkg::REG_SETPOINT:        target_pos = data;
			default:                       ;
		endcase
	endtask

	task automatic apply_setting(input setting_t st);
		cfg_write(REG_UNUSED, 12'($urandom_range(4095, 0)));
		cfg_write(lfps_pkg::REG_GAIN_P, st.gp);
		cfg_write(lfps_pkg::REG_GAIN_I, st.gi);
		cfg_write(lfps_pkg::REG_GAIN_D, st.gd);
		cfg_write(lfps_pkg::REG_BASE_SPEED, st.base);
		cfg_write(lfps_pkg::REG_SPEED_LIMIT, st.limit);
		cfg_write(lfps_pkg::REG_BLACK_THRESHOLD, st.thr);
		cfg_write(lfps_pkg::REG_SETPOINT, st.sp);
		cfg_valid <= 1'b0;
	endtask

	// result side: check each beat, random backpressure
	always @(posedge clk) begin
		lfps_pkg::drive_t want;
		if (arst_n) begin
			if (drive_valid && drive_ready) begin
				if (pending_drive.size() == 0) begin
					fail_count++;
					$error("drive beat with no expected result");
				end else begin
					want = pending_drive.pop_front();
					field_check("left_speed", want.left_speed, drive.left_speed);
					field_check("right_speed", want.right_speed, drive.right_speed);
					field_check("line_seen", want.line_seen, drive.line_seen);
				end
			end
			drive_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		setting_t          st;
		lfps_pkg::sample_t s;
		logic [11:0]       rd [5];
		int                ph, n, k;
		clk = 1'b0;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		drive_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		cycle_count = 0;
		line_run = 0;
		send_idle_pct = 35;
		stall_pct = 58;
		k_p = lfps_pkg::GAIN_P_RST;
		k_i = lfps_pkg::GAIN_I_RST;
		k_d = lfps_pkg::GAIN_D_RST;
		base_spd = lfps_pkg::BASE_SPEED_RST;
		spd_limit = lfps_pkg::SPEED_LIMIT_RST;
		black_thr = lfps_pkg::THRESHOLD_RST;
		target_pos = lfps_pkg::SETPOINT_RST;
		integ_sum = 0;
		last_err = 0;

		// reset register values: gains 51/0/102, base 350, limit 500, threshold 700, setpoint 2500
		add_row(4095, 4095, 4095, 4095, 4095, 0, 1, 350, 350, 0);
		add_row(700, 700, 700, 700, 700, 4000, 1, 350, 350, 0);
		add_row(699, 4095, 4095, 4095, 4095, 2500, 1, 350, 350, 1);
		add_row(4095, 4095, 4095, 4095, 0, 4000, 1, 500, 0, 1);
		add_row(4095, 4095, 0, 4095, 4095, 0, 1, 0, 500, 1);
		add_row(4095, 0, 4095, 4095, 4095, 4095, 0, 0, 0, 0);
		add_row(4095, 4095, 4095, 100, 4095, 2600, 0, 0, 0, 0);
		add_row(0, 0, 0, 0, 0, 2400, 0, 0, 0, 0);
		add_row(4095, 4095, 4095, 4095, 4095, 4095, 1, 350, 350, 0);
		add_row(12'h555, 12'h555, 12'h555, 12'h555, 12'h555, 12'hAAA, 1, 350, 350, 0);
		add_row(12'h2AA, 12'h2AA, 12'h2AA, 12'h2AA, 12'h2AA, 12'hAAA, 0, 0, 0, 0);
		add_row(0, 1, 2, 3, 699, 2501, 0, 0, 0, 0);
		add_row(4095, 4095, 699, 4095, 4095, 2499, 0, 0, 0, 0);
		add_row(4095, 4095, 4095, 0, 4095, 2500, 0, 0, 0, 0);
		add_row(4095, 0, 4095, 4095, 4095, 12'hFFF, 0, 0, 0, 0);
		add_row(4095, 0, 4095, 4095, 4095, 12'hFFF, 0, 0, 0, 0);
		add_row(12'h800, 12'h155, 12'h800, 12'h800, 12'h800, 12'h555, 0, 0, 0, 0);
		add_row(4095, 4095, 4095, 4095, 4095, 2500, 1, 350, 350, 0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);
		wait_idle();

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph / 3)
				0: begin
					send_idle_pct = 35;
					stall_pct = 58;
				end
				1: begin
					send_idle_pct = 58;
					stall_pct = 35;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			if (ph == 0) begin
				st = '{gp: 4095, gi: 4095, gd: 4095, base: 12'hFFF, limit: 12'hFFF,
					thr: 4095, sp: 4000};
			end else if (ph == 1) begin
				st = '{gp: 0, gi: 0, gd: 0, base: 0, limit: 0, thr: 0, sp: 0};
			end else begin
				st.gp = 12'($urandom_range(1) ? $urandom_range(255, 0) :
					$urandom_range(4095, 0));
				st.gi = 12'($urandom_range(1) ? $urandom_range(15, 0) :
					$urandom_range(4095, 0));
				st.gd = 12'($urandom_range(1) ? $urandom_range(255, 0) :
					$urandom_range(4095, 0));
				st.base = 12'($urandom_range(4095, 0));
				st.limit = 12'($urandom_range(4095, 0));
				st.thr = 12'($urandom_range(1) ? $urandom_range(3000, 200) :
					$urandom_range(4095, 0));
				st.sp = 12'(($urandom_range(9) < 7) ? $urandom_range(4000, 0) :
					$urandom_range(4095, 0));
			end
			apply_setting(st);
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				send_sample(random_sample(), 1'b0, '0);
			wait_idle();
		end

		// run at full error so the integral term drives both speeds to the clamps
		send_idle_pct = 0;
		stall_pct = 0;
		st = '{gp: 0, gi: 1, gd: 0, base: 512, limit: 1023, thr: 4095, sp: 0};
		apply_setting(st);
		for (n = 0; n < FULL_ERR_ITEMS; n++) begin
			for (k = 0; k < 5; k++)
				rd[k] = 12'($urandom_range(4095, 0));
			rd[$urandom_range(4, 0)] = 12'($urandom_range(4094, 0));
			s = '{sensor_0: rd[0], sensor_1: rd[1], sensor_2: rd[2], sensor_3: rd[3],
				sensor_4: rd[4], line_position: 12'd4095};
			send_sample(s, 1'b0, '0);
		end

		sample_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
